// File: src/cifvd_pkg.sv
// Shared constants, widths and the side-channel stage type for the cluster index pipeline.
// No dependencies; imported by every module of the block.
package cifvd_pkg;

   localparam int DEPTH_FRAC_BITS = 16;

   localparam int PIX_W      = 14;
   localparam int DEPTH_W    = 32;
   localparam int CFG_W      = 32;
   localparam int TILE_CFG_W = 9;
   localparam int SLICE_W    = 8;

   // natural log unit: 5 normalize steps, 16 squaring rounds, scale, round
   localparam int NORM_STAGES = 5;
   localparam int SQ_STAGES   = 16;
   localparam int LOG_STAGES  = NORM_STAGES + SQ_STAGES + 2;
   localparam int LG2_W       = 6 + SQ_STAGES;
   localparam int LNP_W       = LG2_W + 33;
   localparam int LN_W        = 22;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // tile divider: one quotient bit per stage
   localparam int DIV_STAGES = PIX_W;

   // top-level stage map
   localparam int ST_LV    = LOG_STAGES;
   localparam int ST_PROD  = LOG_STAGES + 1;
   localparam int ST_OUT   = LOG_STAGES + 2;
   localparam int N_STAGES = LOG_STAGES + 3;

   // linear split: n*(depth-near), then one quotient bit per stage
   localparam int LIN_BITS      = SLICE_W;
   localparam int LIN_REM_W     = DEPTH_W + TILE_CFG_W;
   localparam int LIN_MUL_ST    = 1;
   localparam int LIN_DIV_FIRST = 2;
   localparam int TILE_ST       = DIV_STAGES;

   localparam int LV_W   = LN_W + 1;
   localparam int PROD_W = LV_W + CFG_W;
   localparam int T_W    = PROD_W + 1;
   localparam int K_SH   = 16 + DEPTH_FRAC_BITS;
   localparam int K_W    = T_W - K_SH;

   typedef struct packed {
      logic                 dz;
      logic                 low;
      logic                 high;
      logic                 empty;
      logic [LIN_REM_W-1:0] rem;
      logic [LIN_BITS-1:0]  q;
      logic [PIX_W-1:0]     tx;
      logic [PIX_W-1:0]     ty;
   } side_type;

endpackage

// File: src/cluster_index_from_view_depth.sv
// Cluster index from screen position and view depth: one request per cycle while the result side is not stalled.
// Pipeline: the log unit (5 normalize, 16 squaring, 2 scaling stages) plus 3 slice stages.
// Every stage holds only while the stage after it is full and stalled, so bubbles fill in.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// Depends on cifvd_pkg, cifvd_log and cifvd_tile_div.
module cluster_index_from_view_depth
   import cifvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pixel_x[13:0], pixel_y[27:14], view_depth[59:28]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // tile_x[13:0], tile_y[27:14], slice[35:28]
   output logic        rsp_tuser,   // slice_clipped[0]
   // register writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [2:0] REG_TILE_W  = 3'd0;
   localparam logic [2:0] REG_TILE_H  = 3'd1;
   localparam logic [2:0] REG_SLICES  = 3'd2;
   localparam logic [2:0] REG_MODE    = 3'd3;
   localparam logic [2:0] REG_NEAR    = 3'd4;
   localparam logic [2:0] REG_FAR     = 3'd5;
   localparam logic [2:0] REG_SCALE   = 3'd6;
   localparam logic [2:0] REG_OFFSET  = 3'd7;

   localparam logic [1:0] MODE_EXP = 2'd0;
   localparam logic [1:0] MODE_LIN = 2'd1;

   // ---------------- configuration ----------------
   logic [TILE_CFG_W-1:0] tile_w_ff, tile_h_ff, slice_cnt_ff;
   logic [1:0]            mode_ff;
   logic [CFG_W-1:0]      near_ff, far_ff;
   logic signed [CFG_W-1:0] scale_ff, offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_w_ff    <= TILE_CFG_W'(64);
         tile_h_ff    <= TILE_CFG_W'(64);
         slice_cnt_ff <= TILE_CFG_W'(32);
         mode_ff      <= MODE_EXP;
         near_ff      <= 32'd65536;
         far_ff       <= 32'd65536000;
         scale_ff     <= 32'sd65536;
         offset_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_TILE_W: begin
               tile_w_ff <= csr_wdata[TILE_CFG_W-1:0];
            end
            REG_TILE_H: begin
               tile_h_ff <= csr_wdata[TILE_CFG_W-1:0];
            end
            REG_SLICES: begin
               slice_cnt_ff <= csr_wdata[TILE_CFG_W-1:0];
            end
            REG_MODE: begin
               mode_ff <= csr_wdata[1:0];
            end
            REG_NEAR: begin
               near_ff <= csr_wdata;
            end
            REG_FAR: begin
               far_ff <= csr_wdata;
            end
            REG_SCALE: begin
               scale_ff <= csr_wdata;
            end
            REG_OFFSET: begin
               offset_ff <= csr_wdata;
            end
         endcase
      end
   end

   // write registers only while the pipe is empty (unchecked); every stage reads them directly
   logic [TILE_CFG_W-1:0] n_eff;
   logic [SLICE_W-1:0]    n_last;
   logic                  is_lin, is_hyb;
   logic [CFG_W-1:0]      lin_den;

   assign n_eff = (slice_cnt_ff == '0) ? TILE_CFG_W'(1) :
                  (slice_cnt_ff > TILE_CFG_W'(256)) ? TILE_CFG_W'(256) : slice_cnt_ff;
   assign n_last  = SLICE_W'(n_eff - TILE_CFG_W'(1));
   assign is_lin  = (mode_ff == MODE_LIN);
   assign is_hyb  = !is_lin && (mode_ff != MODE_EXP); // unused code acts as hybrid
   assign lin_den = far_ff - near_ff;

   // ---------------- flow control ----------------
   // a stage loads when it is empty or the stage after it loads
   logic [N_STAGES-1:0] v_ff, v_in;
   logic [N_STAGES:0]   en;

   always_comb begin
      en[N_STAGES] = rsp_tready;
      for (int i = N_STAGES - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign v_in       = {v_ff[N_STAGES-2:0], req_tvalid};
   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < N_STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // ---------------- request fields ----------------
   logic [PIX_W-1:0]   req_px, req_py;
   logic [DEPTH_W-1:0] req_depth;

   assign req_px    = req_tdata[13:0];
   assign req_py    = req_tdata[27:14];
   assign req_depth = req_tdata[59:28];

   // ---------------- shared units ----------------
   logic signed [LN_W-1:0] ln_depth, ln_near;
   logic [PIX_W-1:0]       quo_x, quo_y;

   cifvd_log u_log_depth (
      .clock  (clock),
      .en     (en[LOG_STAGES-1:0]),
      .x_in   (req_depth),
      .ln_out (ln_depth)
   );

   // near plane runs alongside so the hybrid form needs no set-up pass
   cifvd_log u_log_near (
      .clock  (clock),
      .en     (en[LOG_STAGES-1:0]),
      .x_in   (near_ff),
      .ln_out (ln_near)
   );

   cifvd_tile_div u_div_x (
      .clock    (clock),
      .en       (en[DIV_STAGES-1:0]),
      .dividend (req_px),
      .divisor  (tile_w_ff),
      .quotient (quo_x)
   );

   cifvd_tile_div u_div_y (
      .clock    (clock),
      .en       (en[DIV_STAGES-1:0]),
      .dividend (req_py),
      .divisor  (tile_h_ff),
      .quotient (quo_y)
   );

   // ---------------- side pipe: linear split, flags, tile indexes ----------------
   side_type side_ff [ST_OUT];
   side_type side_in [ST_OUT];

   for (genvar i = 0; i < ST_OUT; i++) begin : g_side
      if (i == 0) begin : g_first
         // depth window flags; rem holds depth - near for now
         always_comb begin
            side_in[i]       = '0;
            side_in[i].dz    = (req_depth == '0);
            side_in[i].low   = (req_depth < near_ff);
            side_in[i].high  = (req_depth >= far_ff);
            side_in[i].empty = (far_ff <= near_ff);
            side_in[i].rem   = LIN_REM_W'(req_depth - near_ff);
         end
      end else if (i == LIN_MUL_ST) begin : g_mul
         always_comb begin
            side_in[i]     = side_ff[i-1];
            side_in[i].rem = {{TILE_CFG_W{1'b0}}, side_ff[i-1].rem[DEPTH_W-1:0]} *
                             {{DEPTH_W{1'b0}}, n_eff};
         end
      end else if (i >= LIN_DIV_FIRST && i < LIN_DIV_FIRST + LIN_BITS) begin : g_qbit
         localparam int B = LIN_DIV_FIRST + LIN_BITS - 1 - i;
         logic [LIN_REM_W-1:0] dsh;
         assign dsh = LIN_REM_W'(lin_den) << B;
         always_comb begin
            side_in[i] = side_ff[i-1];
            if (side_ff[i-1].rem >= dsh) begin
               side_in[i].rem  = side_ff[i-1].rem - dsh;
               side_in[i].q[B] = 1'b1;
            end
         end
      end else if (i == TILE_ST) begin : g_tile
         always_comb begin
            side_in[i]    = side_ff[i-1];
            side_in[i].tx = quo_x;
            side_in[i].ty = quo_y;
         end
      end else begin : g_copy
         always_comb begin
            side_in[i] = side_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // ---------------- log slice arithmetic ----------------
   logic signed [LV_W-1:0]   lv_ff, lv_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      lv_in = {ln_depth[LN_W-1], ln_depth};
      if (is_hyb) begin
         lv_in = lv_in - {ln_near[LN_W-1], ln_near};
      end
   end

   assign prod_in = lv_ff * scale_ff;

   always_ff @(posedge clock) begin
      if (en[ST_LV]) begin
         lv_ff <= lv_in;
      end
      if (en[ST_PROD]) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------- final select and result register ----------------
   logic signed [T_W-1:0] t_val;
   logic [K_W-1:0]        k_val;
   logic [SLICE_W-1:0]    slice_in;
   logic                  clip_in;
   side_type              fin;

   assign fin   = side_ff[ST_OUT-1];
   // t = ln * scale - offset * 2^16, slice = floor(t / 2^(16 + frac bits))
   assign t_val = {prod_ff[PROD_W-1], prod_ff} -
                  {{(T_W-CFG_W-16){offset_ff[CFG_W-1]}}, offset_ff, 16'b0};
   assign k_val = t_val[T_W-1:K_SH];

   always_comb begin
      slice_in = '0;
      clip_in  = 1'b0;
      if (is_lin) begin
         priority if (fin.empty || fin.low) begin
            clip_in = 1'b1;
         end else if (fin.high) begin
            slice_in = n_last;
            clip_in  = 1'b1;
         end else begin
            slice_in = fin.q;
         end
      end else begin
         // zero depth and below-zero slices clamp to 0, silently only in hybrid
         priority if (fin.dz) begin
            clip_in = !is_hyb;
         end else if (k_val[K_W-1]) begin
            clip_in = !is_hyb;
         end else if (k_val >= K_W'(n_eff)) begin
            slice_in = n_last;
            clip_in  = 1'b1;
         end else begin
            slice_in = k_val[SLICE_W-1:0];
         end
      end
   end

   logic [PIX_W-1:0]   out_tx_ff, out_ty_ff;
   logic [SLICE_W-1:0] out_slice_ff;
   logic               out_clip_ff;

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_tx_ff    <= fin.tx;
         out_ty_ff    <= fin.ty;
         out_slice_ff <= slice_in;
         out_clip_ff  <= clip_in;
      end
   end

   assign rsp_tvalid = v_ff[ST_OUT];
   assign rsp_tdata  = {4'b0, out_slice_ff, out_ty_ff, out_tx_ff};
   assign rsp_tuser  = out_clip_ff;

   // ---------------- checks ----------------
   // nothing left in flight right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // an empty or draining result stage must let the request side flow
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      (!v_ff[ST_OUT] || rsp_tready) |-> req_tready)
      else $error("request stalled while result stage drains");

   // with a nonempty depth range a depth cannot be both below near and past far
   a_lin_flags: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_OUT-1] && !fin.empty) |-> !(fin.low && fin.high))
      else $error("linear window flags contradict");

endmodule

// File: src/cifvd_log.sv
// Pipelined fixed-point natural log: normalize, squaring rounds for the log2 fraction,
// scale by ln 2 and round. Depends on cifvd_pkg; stage enables come from the top level.
module cifvd_log
   import cifvd_pkg::*;
(
   input  logic                   clock,
   input  logic [LOG_STAGES-1:0]  en,
   input  logic [DEPTH_W-1:0]     x_in,
   output logic signed [LN_W-1:0] ln_out
);

   logic [31:0] nm_ff [NORM_STAGES];
   logic [31:0] nm_in [NORM_STAGES];
   logic [4:0]  lz_ff [NORM_STAGES];
   logic [4:0]  lz_in [NORM_STAGES];

   logic [31:0]          sm_ff [SQ_STAGES];
   logic [31:0]          sm_in [SQ_STAGES];
   logic [SQ_STAGES-1:0] fr_ff [SQ_STAGES];
   logic [SQ_STAGES-1:0] fr_in [SQ_STAGES];
   logic [4:0]           sl_ff [SQ_STAGES];

   logic signed [LNP_W-1:0] prod_ff, prod_in;
   logic signed [LN_W-1:0]  ln_ff, ln_in;

   // leading-zero normalize, 16/8/4/2/1; zero acts as one
   for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
      localparam int SH = 16 >> j;
      always_comb begin
         logic [31:0] src;
         logic [4:0]  lzs;
         if (j == 0) begin
            src = (x_in == '0) ? 32'd1 : x_in;
            lzs = '0;
         end else begin
            src = nm_ff[(j == 0) ? 0 : j-1];
            lzs = lz_ff[(j == 0) ? 0 : j-1];
         end
         if (src[31 -: SH] == '0) begin
            nm_in[j] = src << SH;
            lz_in[j] = lzs | 5'(SH);
         end else begin
            nm_in[j] = src;
            lz_in[j] = lzs;
         end
      end
      always_ff @(posedge clock) begin
         if (en[j]) begin
            nm_ff[j] <= nm_in[j];
            lz_ff[j] <= lz_in[j];
         end
      end
   end

   // one fraction bit per squaring of the Q1.31 mantissa
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
      always_comb begin
         logic [31:0]          src;
         logic [SQ_STAGES-1:0] fsrc;
         logic [63:0]          sq;
         logic [32:0]          m2;
         if (k == 0) begin
            src  = nm_ff[NORM_STAGES-1];
            fsrc = '0;
         end else begin
            src  = sm_ff[(k == 0) ? 0 : k-1];
            fsrc = fr_ff[(k == 0) ? 0 : k-1];
         end
         sq = {32'b0, src} * {32'b0, src};
         m2 = sq[63:31];
         fr_in[k] = {fsrc[SQ_STAGES-2:0], m2[32]};
         sm_in[k] = m2[32] ? m2[32:1] : m2[31:0];
      end
      always_ff @(posedge clock) begin
         if (en[NORM_STAGES+k]) begin
            sm_ff[k] <= sm_in[k];
            fr_ff[k] <= fr_in[k];
            sl_ff[k] <= (k == 0) ? lz_ff[NORM_STAGES-1] : sl_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // log2 = (31 - lz - frac bits) . fraction, times ln 2 in Q0.32
   always_comb begin
      logic signed [5:0]       ip;
      logic signed [LG2_W-1:0] lg2;
      ip      = 6'(31 - DEPTH_FRAC_BITS) - {1'b0, sl_ff[SQ_STAGES-1]};
      lg2     = {ip, fr_ff[SQ_STAGES-1]};
      prod_in = lg2 * $signed({1'b0, LN2_Q32});
   end

   // round half up, back to Q.16
   always_comb begin
      logic signed [LNP_W-1:0] rs;
      rs    = prod_ff + (LNP_W'(1) <<< 31);
      ln_in = rs[32+LN_W-1:32];
   end

   always_ff @(posedge clock) begin
      if (en[NORM_STAGES+SQ_STAGES]) begin
         prod_ff <= prod_in;
      end
      if (en[LOG_STAGES-1]) begin
         ln_ff <= ln_in;
      end
   end

   assign ln_out = ln_ff;

endmodule

// File: src/cifvd_tile_div.sv
// Pipelined restoring divider for pixel coordinate over tile size, one quotient bit per stage.
// Depends on cifvd_pkg; stage enables come from the top level.
module cifvd_tile_div
   import cifvd_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  logic [PIX_W-1:0]      dividend,
   input  logic [TILE_CFG_W-1:0] divisor,
   output logic [PIX_W-1:0]      quotient
);

   logic [TILE_CFG_W-1:0] rem_ff  [DIV_STAGES];
   logic [TILE_CFG_W-1:0] rem_in  [DIV_STAGES];
   logic [PIX_W-1:0]      work_ff [DIV_STAGES];
   logic [PIX_W-1:0]      work_in [DIV_STAGES];
   logic [TILE_CFG_W-1:0] dv;

   // a tile size of zero acts as one
   assign dv = (divisor == '0) ? TILE_CFG_W'(1) : divisor;

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
      always_comb begin
         logic [TILE_CFG_W-1:0] rs;
         logic [PIX_W-1:0]      ws;
         logic [TILE_CFG_W:0]   trial;
         if (j == 0) begin
            rs = '0;
            ws = dividend;
         end else begin
            rs = rem_ff[(j == 0) ? 0 : j-1];
            ws = work_ff[(j == 0) ? 0 : j-1];
         end
         trial = {rs, ws[PIX_W-1]};
         if (trial >= {1'b0, dv}) begin
            trial      = trial - {1'b0, dv};
            work_in[j] = {ws[PIX_W-2:0], 1'b1};
         end else begin
            work_in[j] = {ws[PIX_W-2:0], 1'b0};
         end
         rem_in[j] = trial[TILE_CFG_W-1:0];
      end
      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j]  <= rem_in[j];
            work_ff[j] <= work_in[j];
         end
      end
   end

   assign quotient = work_ff[DIV_STAGES-1];

endmodule

// File: test/tb_top.sv
// Self-checking testbench for cluster_index_from_view_depth: stream requests in, cluster indexes out.
// Predicts tile column/row and depth slice per request; depends on cifvd_pkg and the block RTL.
module tb_top;
   import cifvd_pkg::*;

   // register indexes, in the order of the register map
   localparam logic [2:0] REG_TILE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_TILE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_SLICE_COUNT = 3'd2;
   localparam logic [2:0] REG_SPLIT_MODE  = 3'd3;
   localparam logic [2:0] REG_NEAR_DEPTH  = 3'd4;
   localparam logic [2:0] REG_FAR_DEPTH   = 3'd5;
   localparam logic [2:0] REG_SLICE_SCALE = 3'd6;
   localparam logic [2:0] REG_SLICE_OFFS  = 3'd7;

   // depth split modes
   localparam logic [1:0] MODE_EXP    = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_HYBRID = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef struct packed {
      logic [PIX_W-1:0]   tile_x;
      logic [PIX_W-1:0]   tile_y;
      logic [SLICE_W-1:0] slice;
      logic               clipped;
   } cluster_index_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // pixel_x[13:0], pixel_y[27:14], view_depth[59:28]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // tile_x[13:0], tile_y[27:14], slice[35:28]
   logic        rsp_tuser;   // slice_clipped[0]
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // shadow of the block's registers
   logic [8:0]  cfg_tile_w, cfg_tile_h, cfg_slices;
   logic [1:0]  cfg_mode;
   logic [31:0] cfg_near, cfg_far, cfg_scale, cfg_offset;

   cluster_index_type pending_idx[$];
   int  mismatches;
   int  cycles;
   bit  idle_on;       // random gaps and stalls allowed
   int  stall_left;

   cluster_index_from_view_depth i_dut (.*);

   // ---------------------------------------------------------------- clock, reset, watchdog
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   // natural log of a Q16.16 depth as Q.16; zero acts as one lsb
   function automatic longint ln_q16(input logic [31:0] x);
      int          p;
      logic [63:0] m;
      longint      frac, lg2;
      if (x == 32'd0) x = 32'd1;
      p = 31;
      while (p > 0 && !x[p]) p--;
      m = 64'(x) << (31 - p);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      lg2 = longint'(p - DEPTH_FRAC_BITS) * 65536 + frac;
      return (lg2 * longint'(64'(LN2_Q32)) + 64'sh8000_0000) >>> 32;
   endfunction

   function automatic cluster_index_type cluster_of(input logic [13:0] px,
                                                    input logic [13:0] py,
                                                    input logic [31:0] depth);
      cluster_index_type r;
      longint n, k, num, den, lv, t;
      logic [8:0] tw, th;
      bit forced, below_ok;
      tw = (cfg_tile_w == 0) ? 9'd1 : cfg_tile_w;
      th = (cfg_tile_h == 0) ? 9'd1 : cfg_tile_h;
      n  = (cfg_slices == 0) ? 1 : ((cfg_slices > 256) ? 256 : longint'(cfg_slices));
      k = 0; forced = 0; below_ok = 0;
      r.clipped = 1'b0;
      if (cfg_mode == MODE_LINEAR) begin
         num = n * (longint'(depth) - longint'(cfg_near));
         den = longint'(cfg_far) - longint'(cfg_near);
         if (den <= 0) begin
            forced = 1; r.clipped = 1'b1;
         end else if (num >= 0) begin
            k = num / den;
         end else begin
            k = -((-num + den - 1) / den);
         end
      end else begin
         below_ok = (cfg_mode != MODE_EXP);
         if (depth == 0) begin
            forced = 1; r.clipped = !below_ok;
         end else begin
            lv = ln_q16(depth);
            if (below_ok) lv = lv - ln_q16(cfg_near);
            t = lv * longint'(signed'(cfg_scale)) - longint'(signed'(cfg_offset)) * 65536;
            k = t >>> (16 + DEPTH_FRAC_BITS);
         end
      end
      if (forced) begin
         r.slice = '0;
      end else if (k < 0) begin
         r.slice = '0; r.clipped = !below_ok;
      end else if (k > n - 1) begin
         r.slice = SLICE_W'(n - 1); r.clipped = 1'b1;
      end else begin
         r.slice = SLICE_W'(k);
      end
      r.tile_x = PIX_W'(px / tw);
      r.tile_y = PIX_W'(py / th);
      return r;
   endfunction

   // ---------------------------------------------------------------- result checker
   always @(posedge clock) begin
      cluster_index_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[13:0], rsp_tdata[27:14], rsp_tdata[35:28], rsp_tuser};
         if (pending_idx.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h at cycle %0d", got, cycles);
         end else begin
            want = pending_idx.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: tile_x %0d/%0d tile_y %0d/%0d slice %0d/%0d clip %0b/%0b",
                           want.tile_x, got.tile_x, want.tile_y, got.tile_y,
                           want.slice, got.slice, want.clipped, got.clipped);
            end
         end
      end
   end

   // result side back-pressure: random stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- shared tasks
   // one request; valid stays high on return so back-to-back requests need no bubble
   task automatic send_request(input logic [13:0] px, input logic [13:0] py,
                               input logic [31:0] depth);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, depth, py, px};
      do @(posedge clock); while (!req_tready);
      pending_idx.push_back(cluster_of(px, py, depth));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_idx.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_TILE_WIDTH:  cfg_tile_w = value[8:0];
         REG_TILE_HEIGHT: cfg_tile_h = value[8:0];
         REG_SLICE_COUNT: cfg_slices = value[8:0];
         REG_SPLIT_MODE:  cfg_mode   = value[1:0];
         REG_NEAR_DEPTH:  cfg_near   = value;
         REG_FAR_DEPTH:   cfg_far    = value;
         REG_SLICE_SCALE: cfg_scale  = value;
         default:         cfg_offset = value;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // depth spread over all magnitudes, with a few hot spots
   function automatic logic [31:0] rand_depth();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return cfg_near + $urandom_range(0, 3) - 1;
         3:       return cfg_far + $urandom_range(0, 3) - 1;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [13:0] rand_pix();
      return ($urandom_range(0, 7) == 0) ? 14'h3FFF : 14'($urandom);
   endfunction

   // ---------------------------------------------------------------- tests
   // reset defaults: exponential split, 64x64 tiles, 32 slices
   task automatic test_defaults;
      send_request(14'd0, 14'd0, 32'd0);              // zero depth, exponential: clipped
      send_request(14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF);
      send_request(14'd63, 14'd64, ONE_Q16);
      send_request(14'd64, 14'd63, 32'd1);
      send_request(14'h2AAA, 14'h1555, 32'd20 << 16);
      send_request(14'h1555, 14'h2AAA, 32'h0000_8000);
   endtask

   task automatic test_special_cases;
      write_reg(REG_TILE_WIDTH, 32'd0);                // zero tile size acts as 1
      write_reg(REG_TILE_HEIGHT, 32'd256);
      write_reg(REG_SLICE_COUNT, 32'd0);               // acts as one slice
      send_request(14'h3FFF, 14'h3FFF, 32'd5 << 16);
      send_request(14'd1, 14'd255, 32'd0);
      write_reg(REG_SLICE_COUNT, 32'h1FF);             // above 256 acts as 256
      write_reg(REG_SLICE_SCALE, 32'd40 << 16);
      send_request(14'd7, 14'd256, 32'hFFFF_FFFF);
      write_reg(REG_SPLIT_MODE, MODE_LINEAR);
      send_request(14'd0, 14'd0, 32'd500 << 16);
      send_request(14'd0, 14'd0, 32'd0);                 // below near
      send_request(14'd0, 14'd0, 32'hFFFF_FFFF);         // beyond far
      write_reg(REG_FAR_DEPTH, ONE_Q16);                 // far equals near: empty range
      send_request(14'd3, 14'd3, 32'd2 << 16);
      write_reg(REG_SPLIT_MODE, MODE_HYBRID);
      write_reg(REG_SLICE_OFFS, 32'hFFFF_0000);          // -1.0
      send_request(14'd0, 14'd0, 32'd0);                 // zero depth, hybrid: not clipped
      send_request(14'd0, 14'd0, 32'h0000_4000);         // below zero clamps quietly
      send_request(14'd0, 14'd0, 32'd100 << 16);
      write_reg(REG_NEAR_DEPTH, 32'd0);                  // zero near acts as one lsb
      send_request(14'd9, 14'd9, 32'd1);
      send_request(14'd9, 14'd9, 32'hFFFF_FFFF);
      write_reg(REG_SPLIT_MODE, MODE_UNUSED);            // acts as hybrid
      write_reg(REG_SLICE_SCALE, 32'h8000_0000);         // most negative scale
      send_request(14'd9, 14'd9, 32'd3);
      write_reg(REG_SLICE_SCALE, 32'h7FFF_FFFF);
      write_reg(REG_SLICE_OFFS, 32'h8000_0000);
      send_request(14'd9, 14'd9, 32'd3);
   endtask

   // random register set, with some probability of each extreme
   task automatic load_random_config;
      logic [31:0] near, far;
      write_reg(REG_TILE_WIDTH, $urandom_range(0, 3) == 0 ? 32'h1FF : $urandom_range(0, 300));
      write_reg(REG_TILE_HEIGHT, $urandom_range(0, 3) == 0 ? 32'd1 : $urandom_range(0, 511));
      write_reg(REG_SLICE_COUNT, $urandom_range(0, 3) == 0 ? 32'd256 : $urandom_range(0, 511));
      write_reg(REG_SPLIT_MODE, $urandom_range(0, 3));
      near = $urandom >> $urandom_range(0, 31);
      far  = ($urandom_range(0, 7) == 0) ? $urandom : near + ($urandom >> $urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) far = 32'hFFFF_FFFF;
      write_reg(REG_NEAR_DEPTH, near);
      write_reg(REG_FAR_DEPTH, far);
      // mostly modest scales so slices land inside the grid, sometimes full range
      write_reg(REG_SLICE_SCALE, $urandom_range(0, 4) == 0 ? $urandom
                                 : 32'($urandom_range(0, 32 << 16)) - (32'd4 << 16));
      write_reg(REG_SLICE_OFFS, $urandom_range(0, 4) == 0 ? $urandom
                                : 32'($urandom_range(0, 64 << 16)) - (32'd32 << 16));
   endtask

   task automatic test_random_phases;
      for (int ph = 0; ph < 10; ph++) begin
         load_random_config();
         if (ph == 9) idle_on = 0;   // final stretch at full rate
         for (int i = 0; i < 160; i++)
            send_request(rand_pix(), rand_pix(), rand_depth());
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = REG_TILE_WIDTH;
      csr_wdata  = '0;
      cycles     = 0;
      mismatches = 0;
      stall_left = 0;
      idle_on    = 1;
      cfg_tile_w = 9'd64;  cfg_tile_h = 9'd64;  cfg_slices = 9'd32;
      cfg_mode   = MODE_EXP;
      cfg_near   = ONE_Q16; cfg_far = 32'd65536000;
      cfg_scale  = ONE_Q16; cfg_offset = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_defaults();
      test_special_cases();
      test_random_phases();

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_idx.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: cluster_index_from_view_depth.f
src/cifvd_pkg.sv
src/cifvd_log.sv
src/cifvd_tile_div.sv
src/cluster_index_from_view_depth.sv
test/tb_top.sv
